// ===== src/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define IPT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define IPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/ipt_pkg.sv =====
// shared types and constants for the ipv6 prefix translation block
`default_nettype none

package ipt_pkg;

	localparam int ADDR_W = 128;

	localparam logic [1:0] MODE_CLEAR   = 2'd0;
	localparam logic [1:0] MODE_APPEND  = 2'd1;
	localparam logic [1:0] MODE_RESOLVE = 2'd2;
	localparam logic [1:0] MODE_GLOBAL  = 2'd3;

	localparam logic [2:0] ST_FWD     = 3'd0;
	localparam logic [2:0] ST_REV     = 3'd1;
	localparam logic [2:0] ST_MISS    = 3'd2;
	localparam logic [2:0] ST_ADDED   = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;
	localparam logic [2:0] ST_BADLEN  = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	localparam logic [7:0] PLEN_MAX  = 8'd128;
	localparam logic [7:0] GUA_MASK  = 8'hE0;
	localparam logic [7:0] GUA_VALUE = 8'h20;

	// one table row: prefixes, the precomputed prefix mask and the interface
	typedef struct packed {
		logic [ADDR_W-1:0] inner;
		logic [ADDR_W-1:0] outer;
		logic [ADDR_W-1:0] mask;
		logic [7:0]        iface;
	} ipt_rec_t;

	typedef struct packed {
		logic              hit;
		logic              gua;
		logic [ADDR_W-1:0] result;
		logic [7:0]        iface;
	} ipt_match_t;

endpackage

`default_nettype wire

// ===== src/ipv6_prefix_map_translate.sv =====
// ipv6 prefix mapping table: clear, append, resolve and global lookup, one entry read per cycle
// clear and append go through the exec and result states before their result is loaded for output
// lookup: one pass reads one table row per cycle from the single table ram
// resolve: up to two passes, a forward pass and then a reverse pass; global lookup takes one pass
// one item at a time; the next input beat is taken once the result is queued for output
// reset clears the entry count, control and output registers; the table ram keeps its contents
`default_nettype none

module ipv6_prefix_map_translate import ipt_pkg::*; #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// addr_high, addr_low, ext_high, ext_low, plen, iface_in
	input  wire logic [271:0] s_tdata,
	// mode
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_high, result_low, iface_out, entry_total, zero pad
	output logic [143:0]      m_tdata,
	// status
	output logic [2:0]        m_tuser
);

	`include "assert_macros.svh"

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_RESULT} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              pass_q;
	logic              rd_vld_s1;
	logic [2:0]        res_status_q;
	logic [ADDR_W-1:0] res_data_q;
	logic [7:0]        res_iface_q;

	logic [1:0]        mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] ext_q;
	logic [7:0]        plen_q;
	logic [7:0]        iface_q;

	logic              accept;
	logic              wr_en;
	logic              rd_en;
	logic              out_load;
	logic              hit_ok;
	logic              scan_end;
	ipt_rec_t          wr_rec;
	ipt_rec_t          rd_rec;
	ipt_match_t        mt;
	logic [CNT_W+6:0]  cnt_ext;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_load = (state_q == S_RESULT) && (!m_tvalid || m_tready);
	assign wr_en    = (state_q == S_EXEC) && (mode_q == MODE_APPEND)
	                  && (plen_q <= PLEN_MAX) && (cnt_q != CNT_FULL);
	assign rd_en    = (state_q == S_SCAN) && (rd_idx_q < n_q);
	assign hit_ok   = rd_vld_s1 && mt.hit && ((mode_q != MODE_GLOBAL) || mt.gua);
	assign scan_end = !rd_vld_s1 && (rd_idx_q == n_q);
	assign cnt_ext  = {7'd0, cnt_q};

	always_comb begin
		wr_rec.inner = addr_q;
		wr_rec.outer = ext_q;
		wr_rec.mask  = ~({ADDR_W{1'b1}} >> plen_q);
		wr_rec.iface = iface_q;
	end

	ipt_ram #(
		.WIDTH($bits(ipt_rec_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (wr_rec),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (rd_rec)
	);

	ipt_match u_match (
		.addr    (addr_q),
		.rec     (rd_rec),
		.reverse (pass_q),
		.mt      (mt)
	);

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= s_tuser;
			addr_q  <= {s_tdata[63:0], s_tdata[127:64]};
			ext_q   <= {s_tdata[191:128], s_tdata[255:192]};
			plen_q  <= s_tdata[263:256];
			iface_q <= s_tdata[271:264];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			n_q          <= '0;
			rd_idx_q     <= '0;
			pass_q       <= 1'b0;
			rd_vld_s1    <= 1'b0;
			res_status_q <= ST_MISS;
			res_data_q   <= '0;
			res_iface_q  <= '0;
			m_tvalid     <= 1'b0;
			m_tdata      <= '0;
			m_tuser      <= '0;
		end else begin
			// a new beat loaded in the same cycle keeps valid high
			if (m_tvalid && m_tready && !out_load) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_data_q  <= '0;
					res_iface_q <= '0;
					case (mode_q)
						MODE_CLEAR: begin
							cnt_q        <= '0;
							res_status_q <= ST_CLEARED;
							state_q      <= S_RESULT;
						end
						MODE_APPEND: begin
							if (plen_q > PLEN_MAX) begin
								res_status_q <= ST_BADLEN;
							end else if (cnt_q == CNT_FULL) begin
								res_status_q <= ST_FULL;
							end else begin
								cnt_q        <= cnt_q + 1'b1;
								res_status_q <= ST_ADDED;
							end
							state_q <= S_RESULT;
						end
						default: begin
							n_q       <= cnt_q;
							rd_idx_q  <= '0;
							pass_q    <= 1'b0;
							rd_vld_s1 <= 1'b0;
							state_q   <= S_SCAN;
						end
					endcase
				end
				S_SCAN: begin
					if (hit_ok) begin
						res_status_q <= pass_q ? ST_REV : ST_FWD;
						res_data_q   <= mt.result;
						res_iface_q  <= mt.iface;
						rd_vld_s1    <= 1'b0;
						state_q      <= S_RESULT;
					end else if (scan_end) begin
						// no forward hit on resolve: rescan for external prefixes
						if ((mode_q == MODE_RESOLVE) && !pass_q) begin
							pass_q   <= 1'b1;
							rd_idx_q <= '0;
						end else begin
							res_status_q <= ST_MISS;
							res_data_q   <= '0;
							res_iface_q  <= '0;
							state_q      <= S_RESULT;
						end
					end else begin
						rd_vld_s1 <= rd_en;
						if (rd_en) begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
				end
				S_RESULT: begin
					if (out_load) begin
						m_tvalid <= 1'b1;
						m_tuser  <= res_status_q;
						m_tdata  <= {1'b0, cnt_ext[6:0], res_iface_q,
						             res_data_q[63:0], res_data_q[127:64]};
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`IPT_ASSERT(a_cnt_bound, cnt_q <= CNT_FULL, "entry count beyond table depth")
	`IPT_ASSERT_IMP(a_wr_below_full, wr_en, cnt_q < CNT_FULL, "table write at full table")
	`IPT_ASSERT_IMP(a_rd_in_range, rd_en, rd_idx_q < n_q && n_q <= cnt_q,
		"table read beyond filled entries")
	`IPT_ASSERT_IMP(a_load_free, out_load, !m_tvalid || m_tready,
		"result loaded over a pending beat")

endmodule

`default_nettype wire

// ===== src/ipt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`default_nettype none

module ipt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    wr_en,
	input  wire logic [AW-1:0]           wr_addr,
	input  wire logic [WIDTH-1:0]        wr_data,
	input  wire logic                    rd_en,
	input  wire logic [AW-1:0]           rd_addr,
	output logic      [WIDTH-1:0]        rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ipt_match.sv =====
// prefix compare and rewrite of one table row against the lookup address
`default_nettype none

module ipt_match import ipt_pkg::*; (
	input  wire logic [ADDR_W-1:0] addr,
	input  wire ipt_rec_t          rec,
	input  wire logic              reverse,
	output ipt_match_t             mt
);

	logic [ADDR_W-1:0] cmp_pfx;
	logic [ADDR_W-1:0] new_pfx;

	always_comb begin
		// forward pass matches inner and writes outer, reverse the other way
		cmp_pfx   = reverse ? rec.outer : rec.inner;
		new_pfx   = reverse ? rec.inner : rec.outer;
		mt.hit    = (((addr ^ cmp_pfx) & rec.mask) == '0);
		mt.result = (new_pfx & rec.mask) | (addr & ~rec.mask);
		mt.gua    = ((mt.result[ADDR_W-1 -: 8] & GUA_MASK) == GUA_VALUE);
		mt.iface  = rec.iface;
	end

endmodule

`default_nettype wire
